// ===== hw/rtl/sck_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types, constants and tables for the slider-crank kinematics unit.
// ----------------------------------------------------------------------------
package sck_pkg;

    localparam int NUM_PISTONS_DEF = 3;
    localparam int CORDIC_STEPS    = 16;

    // ceil(2^72 / 234375): phase step = floor(rpm * us * PHASE_RCP / 2^48)
    localparam logic [54:0] PHASE_RCP   = 55'd20148763660243820;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    localparam logic [2:0] REG_RPM    = 3'd0;
    localparam logic [2:0] REG_RADIUS = 3'd1;
    localparam logic [2:0] REG_ROD    = 3'd2;
    localparam logic [2:0] REG_CX     = 3'd3;
    localparam logic [2:0] REG_CY     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_T, S_RCP_LO, S_RCP_HI, S_PHASE, S_ROT_INIT, S_ROT,
        S_MUL_S, S_MUL_C, S_MUL_L, S_MUL_R, S_RAD, S_SQRT, S_VEC_INIT,
        S_VEC, S_EMIT
    } sck_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MUL_T, OP_RCP_LO, OP_RCP_HI, OP_PHASE,
        OP_ROT_INIT, OP_ROT_STEP, OP_MUL_S, OP_MUL_C, OP_MUL_L, OP_MUL_R,
        OP_RAD, OP_SQRT_STEP, OP_VEC_INIT, OP_VEC_STEP, OP_EMIT
    } sck_op_t;

    typedef struct packed {
        sck_op_t    op;
        logic [3:0] step;
        logic [2:0] piston;
        logic       last;
    } sck_cmd_t;

    typedef struct packed {
        logic out_free;
    } sck_sts_t;

    function automatic logic [31:0] atan_q32(input logic [3:0] i);
        logic [31:0] v;
        unique case (i)
            4'd0:  v = 32'd536870912;
            4'd1:  v = 32'd316933406;
            4'd2:  v = 32'd167458907;
            4'd3:  v = 32'd85004756;
            4'd4:  v = 32'd42667331;
            4'd5:  v = 32'd21354465;
            4'd6:  v = 32'd10679838;
            4'd7:  v = 32'd5340245;
            4'd8:  v = 32'd2670163;
            4'd9:  v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            4'd15: v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        logic [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sck_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sck_ctrl
// Sequencer: steps the datapath through phase update and per-piston math.
// ----------------------------------------------------------------------------
module sck_ctrl #(
    parameter int NUM_PISTONS = sck_pkg::NUM_PISTONS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire sck_pkg::sck_sts_t sts,
    output sck_pkg::sck_cmd_t cmd
);

    sck_pkg::sck_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [2:0] piston_reg, piston_next;
    logic       last;
    logic       step_end16;

    assign last       = (piston_reg == 3'(NUM_PISTONS - 1));
    assign step_end16 = (step_reg == 4'(sck_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sck_pkg::S_IDLE;
            step_reg   <= '0;
            piston_reg <= '0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            piston_reg <= piston_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = '0;
        piston_next = piston_reg;
        unique case (state_reg)
            sck_pkg::S_IDLE: begin
                piston_next = '0;
                if (s_valid) state_next = sck_pkg::S_MUL_T;
            end
            sck_pkg::S_MUL_T:    state_next = sck_pkg::S_RCP_LO;
            sck_pkg::S_RCP_LO:   state_next = sck_pkg::S_RCP_HI;
            sck_pkg::S_RCP_HI:   state_next = sck_pkg::S_PHASE;
            sck_pkg::S_PHASE:    state_next = sck_pkg::S_ROT_INIT;
            sck_pkg::S_ROT_INIT: state_next = sck_pkg::S_ROT;
            sck_pkg::S_ROT: begin
                if (step_end16) state_next = sck_pkg::S_MUL_S;
                else step_next = step_reg + 4'd1;
            end
            sck_pkg::S_MUL_S: state_next = sck_pkg::S_MUL_C;
            sck_pkg::S_MUL_C: state_next = sck_pkg::S_MUL_L;
            sck_pkg::S_MUL_L: state_next = sck_pkg::S_MUL_R;
            sck_pkg::S_MUL_R: state_next = sck_pkg::S_RAD;
            sck_pkg::S_RAD:   state_next = sck_pkg::S_SQRT;
            sck_pkg::S_SQRT: begin
                if (step_end16) state_next = sck_pkg::S_VEC_INIT;
                else step_next = step_reg + 4'd1;
            end
            sck_pkg::S_VEC_INIT: state_next = sck_pkg::S_VEC;
            sck_pkg::S_VEC: begin
                if (step_end16) state_next = sck_pkg::S_EMIT;
                else step_next = step_reg + 4'd1;
            end
            sck_pkg::S_EMIT: begin
                if (sts.out_free) begin
                    if (last) begin
                        state_next = sck_pkg::S_IDLE;
                    end else begin
                        piston_next = piston_reg + 3'd1;
                        state_next  = sck_pkg::S_ROT_INIT;
                    end
                end
            end
            default: state_next = sck_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == sck_pkg::S_IDLE);
        cmd.step   = step_reg;
        cmd.piston = piston_reg;
        cmd.last   = last;
        unique case (state_reg)
            sck_pkg::S_IDLE:     cmd.op = s_valid ? sck_pkg::OP_LOAD : sck_pkg::OP_NONE;
            sck_pkg::S_MUL_T:    cmd.op = sck_pkg::OP_MUL_T;
            sck_pkg::S_RCP_LO:   cmd.op = sck_pkg::OP_RCP_LO;
            sck_pkg::S_RCP_HI:   cmd.op = sck_pkg::OP_RCP_HI;
            sck_pkg::S_PHASE:    cmd.op = sck_pkg::OP_PHASE;
            sck_pkg::S_ROT_INIT: cmd.op = sck_pkg::OP_ROT_INIT;
            sck_pkg::S_ROT:      cmd.op = sck_pkg::OP_ROT_STEP;
            sck_pkg::S_MUL_S:    cmd.op = sck_pkg::OP_MUL_S;
            sck_pkg::S_MUL_C:    cmd.op = sck_pkg::OP_MUL_C;
            sck_pkg::S_MUL_L:    cmd.op = sck_pkg::OP_MUL_L;
            sck_pkg::S_MUL_R:    cmd.op = sck_pkg::OP_MUL_R;
            sck_pkg::S_RAD:      cmd.op = sck_pkg::OP_RAD;
            sck_pkg::S_SQRT:     cmd.op = sck_pkg::OP_SQRT_STEP;
            sck_pkg::S_VEC_INIT: cmd.op = sck_pkg::OP_VEC_INIT;
            sck_pkg::S_VEC:      cmd.op = sck_pkg::OP_VEC_STEP;
            sck_pkg::S_EMIT:     cmd.op = sck_pkg::OP_EMIT;
            default:             cmd.op = sck_pkg::OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == sck_pkg::S_MUL_T))
        else $error("accepted item did not start the multiply");
    a_phase_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sck_pkg::S_RCP_HI) |=> (state_reg == sck_pkg::S_PHASE))
        else $error("phase step sequence wrong");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sck_pkg::S_EMIT && last && sts.out_free)
        |=> (state_reg == sck_pkg::S_IDLE && piston_reg == 3'(NUM_PISTONS - 1)))
        else $error("last piston did not end the tick");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sck_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sck_dp
// Datapath: config, phase step multiplier, shared CORDIC, multiplier, root,
// outputs.
// ----------------------------------------------------------------------------
module sck_dp (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic [15:0] s_elapsed_us,
    input  wire sck_pkg::sck_cmd_t cmd,
    output sck_pkg::sck_sts_t sts,
    input  wire logic        m_ready,
    output logic             m_valid,
    output logic [2:0]       m_piston_index,
    output logic [15:0]      m_crank_pin_x,
    output logic [15:0]      m_crank_pin_y,
    output logic [15:0]      m_pin_y,
    output logic [15:0]      m_rod_mid_x,
    output logic [15:0]      m_rod_mid_y,
    output logic [15:0]      m_rod_angle,
    output logic [15:0]      m_crank_angle,
    output logic             m_radicand_clamped,
    output logic             m_last
);

    logic [13:0]        rpm_reg;
    logic [14:0]        radius_reg, rod_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [31:0]        phase_reg;
    logic [15:0]        us_reg;
    logic [29:0]        tprod_reg;
    logic [57:0]        plo_reg;
    logic [56:0]        phi_reg;
    logic [31:0]        ph_reg;
    logic               flip_reg;
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [49:0] mprod_reg, mprod_next;
    logic signed [17:0] rs_reg, rc_reg;
    logic [29:0]        ll_reg;
    logic               clamped_reg, zero_reg;
    logic [30:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic               m_valid_reg;

    logic [3:0]         idx;
    logic signed [35:0] xs, ys, atan_ext;
    logic [79:0]        rcp_sum;
    logic signed [35:0] s_neg, c_neg;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [49:0] rnd;
    logic signed [33:0] rad;
    logic [31:0]        sq_sum;
    logic               sq_ge;
    logic [31:0]        ph_piston, a_fold;
    logic signed [35:0] vx0, vy0;
    logic signed [19:0] cx20, cy20, rs20, rc20, root20, cpy20, py20;
    logic signed [19:0] mx20, my20;
    logic [31:0]        ang, ang_rnd;
    logic               vec_pos;

    assign idx      = cmd.step;
    assign xs       = x_reg >>> idx;
    assign ys       = y_reg >>> idx;
    assign atan_ext = $signed({4'b0, sck_pkg::atan_q32(idx)});
    assign rcp_sum  = {phi_reg[51:0], 28'b0} + {22'b0, plo_reg};
    assign s_neg    = flip_reg ? -y_reg : y_reg;
    assign c_neg    = flip_reg ? -x_reg : x_reg;
    assign rnd      = mprod_reg + 50'sd536870912;
    assign rad      = $signed({4'b0, ll_reg}) - mprod_reg[33:0];
    assign sq_sum   = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge    = ({1'b0, sq_v_reg} >= sq_sum);
    assign ph_piston = phase_reg + {cmd.piston[0], 31'b0};
    assign a_fold   = {ph_piston[31] ^ (ph_piston[31] ^ ph_piston[30]), ph_piston[30:0]};
    assign vx0      = $signed({{18{rs_reg[17]}}, rs_reg}) <<< 14;
    assign vy0      = $signed({5'b0, sq_res_reg[15:0], 14'b0});
    assign vec_pos  = !y_reg[35] && (y_reg != 36'sd0);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (cmd.op)
            sck_pkg::OP_MUL_S: begin
                mul_a = s_neg[31:0];
                mul_b = $signed({3'b0, radius_reg});
            end
            sck_pkg::OP_MUL_C: begin
                mul_a = c_neg[31:0];
                mul_b = $signed({3'b0, radius_reg});
            end
            sck_pkg::OP_MUL_L: begin
                mul_a = $signed({17'b0, rod_reg});
                mul_b = $signed({3'b0, rod_reg});
            end
            sck_pkg::OP_MUL_R: begin
                mul_a = $signed({{14{rs_reg[17]}}, rs_reg});
                mul_b = rs_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mprod_next = mul_a * mul_b;
    end

    always_comb begin
        cx20   = 20'(cx_reg);
        cy20   = 20'(cy_reg);
        rs20   = 20'(rs_reg);
        rc20   = 20'(rc_reg);
        root20 = $signed({4'b0, sq_res_reg[15:0]});
        cpy20  = cy20 + rc20;
        py20   = rc20 + root20 + cy20;
        mx20   = ((cx20 <<< 1) - rs20) >>> 1;
        my20   = (py20 + cpy20) >>> 1;
        ang    = zero_reg ? 32'd0 : z_reg[31:0];
        ang_rnd = ang + 32'h0000_8000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpm_reg     <= 14'd100;
            radius_reg  <= 15'd51;
            rod_reg     <= 15'd512;
            cx_reg      <= 16'sd1024;
            cy_reg      <= 16'sd512;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sck_pkg::REG_RPM:    rpm_reg    <= cfg_wdata[13:0];
                    sck_pkg::REG_RADIUS: radius_reg <= cfg_wdata[14:0];
                    sck_pkg::REG_ROD:    rod_reg    <= cfg_wdata[14:0];
                    sck_pkg::REG_CX:     cx_reg     <= cfg_wdata;
                    sck_pkg::REG_CY:     cy_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op == sck_pkg::OP_PHASE) phase_reg <= phase_reg + rcp_sum[79:48];
            if (cmd.op == sck_pkg::OP_EMIT && sts.out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mprod_reg <= mprod_next;
        unique case (cmd.op)
            sck_pkg::OP_LOAD: us_reg <= s_elapsed_us;
            sck_pkg::OP_MUL_T: tprod_reg <= 30'({16'b0, rpm_reg} * {14'b0, us_reg});
            sck_pkg::OP_RCP_LO:
                plo_reg <= {28'b0, tprod_reg} * {30'b0, sck_pkg::PHASE_RCP[27:0]};
            sck_pkg::OP_RCP_HI:
                phi_reg <= {27'b0, tprod_reg} * {30'b0, sck_pkg::PHASE_RCP[54:28]};
            sck_pkg::OP_ROT_INIT: begin
                ph_reg   <= ph_piston;
                flip_reg <= ph_piston[31] ^ ph_piston[30];
                x_reg    <= $signed({4'b0, sck_pkg::CORDIC_GAIN});
                y_reg    <= '0;
                z_reg    <= $signed({{4{a_fold[31]}}, a_fold});
            end
            sck_pkg::OP_ROT_STEP: begin
                if (!z_reg[35]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_ext;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_ext;
                end
            end
            sck_pkg::OP_MUL_C: rs_reg <= rnd[47:30];
            sck_pkg::OP_MUL_L: rc_reg <= rnd[47:30];
            sck_pkg::OP_MUL_R: ll_reg <= mprod_reg[29:0];
            sck_pkg::OP_RAD: begin
                clamped_reg <= rad[33];
                sq_v_reg    <= rad[33] ? 31'd0 : rad[30:0];
                sq_res_reg  <= '0;
                sq_bit_reg  <= 31'h4000_0000;
            end
            sck_pkg::OP_SQRT_STEP: begin
                if (sq_ge) begin
                    sq_v_reg   <= 31'({1'b0, sq_v_reg} - sq_sum);
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            sck_pkg::OP_VEC_INIT: begin
                zero_reg <= (rs_reg == 18'sd0) && (sq_res_reg == 31'd0);
                if (rs_reg[17]) begin
                    x_reg <= vy0;
                    y_reg <= -vx0;
                    z_reg <= 36'sd1073741824;
                end else begin
                    x_reg <= vx0;
                    y_reg <= vy0;
                    z_reg <= '0;
                end
            end
            sck_pkg::OP_VEC_STEP: begin
                if (vec_pos) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_ext;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_ext;
                end
            end
            sck_pkg::OP_EMIT: begin
                if (sts.out_free) begin
                    m_piston_index     <= cmd.piston;
                    m_crank_pin_x      <= sck_pkg::sat16(cx20 - rs20);
                    m_crank_pin_y      <= sck_pkg::sat16(cpy20);
                    m_pin_y            <= sck_pkg::sat16(py20);
                    m_rod_mid_x        <= sck_pkg::sat16(mx20);
                    m_rod_mid_y        <= sck_pkg::sat16(my20);
                    m_rod_angle        <= ang_rnd[31:16] + 16'h4000;
                    m_crank_angle      <= ph_reg[31:16];
                    m_radicand_clamped <= clamped_reg;
                    m_last             <= cmd.last;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == sck_pkg::OP_EMIT && sts.out_free) |=> m_valid_reg)
        else $error("result not presented after emit");
    a_clamp_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == sck_pkg::OP_SQRT_STEP && clamped_reg) |-> (sq_res_reg == 31'd0))
        else $error("clamped radicand gave nonzero root");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready)
        |=> (m_valid_reg && $stable(m_crank_angle) && $stable(m_piston_index)))
        else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/slider_crank_kinematics_unit.sv =====
// Sequence: an accepted item first computes the phase step and advances the
// phase, then each piston runs in turn (two 16-step CORDIC passes, 16-step
// root) and emits one result; a new item is accepted only after the last
// piston's result has been emitted.
// A result held by m_ready stalls the sequence for as long as it waits.
// Reset: synchronous active-low aresetn restores config defaults, zeroes phase.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slider_crank_kinematics_unit
// Crank phase integrator and per-piston slider-crank geometry.
// ----------------------------------------------------------------------------
module slider_crank_kinematics_unit #(
    parameter int NUM_PISTONS = sck_pkg::NUM_PISTONS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_elapsed_us,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_piston_index,
    output logic [15:0]      m_crank_pin_x,
    output logic [15:0]      m_crank_pin_y,
    output logic [15:0]      m_pin_y,
    output logic [15:0]      m_rod_mid_x,
    output logic [15:0]      m_rod_mid_y,
    output logic [15:0]      m_rod_angle,
    output logic [15:0]      m_crank_angle,
    output logic             m_radicand_clamped,
    output logic             m_last
);

    sck_pkg::sck_cmd_t cmd;
    sck_pkg::sck_sts_t sts;

    sck_ctrl #(.NUM_PISTONS(NUM_PISTONS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sck_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_elapsed_us       (s_elapsed_us),
        .cmd                (cmd),
        .sts                (sts),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_piston_index     (m_piston_index),
        .m_crank_pin_x      (m_crank_pin_x),
        .m_crank_pin_y      (m_crank_pin_y),
        .m_pin_y            (m_pin_y),
        .m_rod_mid_x        (m_rod_mid_x),
        .m_rod_mid_y        (m_rod_mid_y),
        .m_rod_angle        (m_rod_angle),
        .m_crank_angle      (m_crank_angle),
        .m_radicand_clamped (m_radicand_clamped),
        .m_last             (m_last)
    );

endmodule
`default_nettype wire
